@@ src/modbus_rtu_reply_checker_assert.svh @@
// Assertion macros for the reply checker's port-level checker.
`ifndef MODBUS_RTU_REPLY_CHECKER_ASSERT_SVH
`define MODBUS_RTU_REPLY_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MRC_ASSERT_NOW(label, clk, rst, cond_a, cond_c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_c)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRC_ASSERT_NEXT(label, clk, rst, cond_a, cond_c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_c)) \
      else $error(msg);

`endif

@@ src/mrc_pkg.sv @@
// Types, constants, CRC and function-code helpers for the Modbus RTU reply checker.
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

   localparam int REPLY_BUFFER_BYTES_DEFAULT = 64;
   localparam int MIN_REPLY_BYTES            = 5;
   localparam int EXCEPTION_BIT              = 7;

   localparam logic [15:0] CRC_SEED      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_WRONG_ID  = 3'd2,
      ST_CRC_FAIL  = 3'd3,
      ST_EXCEPTION = 3'd4,
      ST_ILLEGAL   = 3'd5,
      ST_TIMEOUT   = 3'd6
   } status_type;

   typedef enum logic [7:0] {
      FC_READ_COILS      = 8'd1,
      FC_READ_INPUTS     = 8'd2,
      FC_READ_HOLDING    = 8'd3,
      FC_READ_INPUT_REGS = 8'd4,
      FC_WRITE_COIL      = 8'd5,
      FC_WRITE_REG       = 8'd6,
      FC_WRITE_COILS     = 8'd15,
      FC_WRITE_REGS      = 8'd16
   } function_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  function_code;
      logic [6:0]  reply_length;
      logic [15:0] success_count;
      logic [15:0] failed_count;
      logic [15:0] exception_count;
      logic [15:0] retry_count;
   } rsp_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic known_function(input logic [7:0] f);
      return (f == FC_READ_COILS) || (f == FC_READ_INPUTS) || (f == FC_READ_HOLDING) ||
             (f == FC_READ_INPUT_REGS) || (f == FC_WRITE_COIL) || (f == FC_WRITE_REG) ||
             (f == FC_WRITE_COILS) || (f == FC_WRITE_REGS);
   endfunction

endpackage

`default_nettype wire

@@ src/modbus_rtu_reply_checker.sv @@
// Top level of the Modbus RTU master reply checker.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   mrc_pkg::req_type
//   rsp      out        rsp_valid / rsp_ready   mrc_pkg::rsp_type
//   csr      in         csr_write_enable        timeout_ticks, 16 bits
//
// One item per cycle while no result is held: a transfer lands in the input register,
// and a single pass on it updates the frame state and result register (byte-wide CRC).
// rsp_valid is registered, so it rises only after that pass on the req transfer's item.
// Reset is synchronous; it empties both registers and restores the timeout to 1000.
// A held result stalls the pass; the input register still takes one more item.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_reply_checker #(
   parameter int REPLY_BUFFER_BYTES = mrc_pkg::REPLY_BUFFER_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mrc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mrc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [15:0]      csr_write_data
);

   localparam int CNT_BITS = $clog2(REPLY_BUFFER_BYTES + 2);
   localparam int CNT_W    = (CNT_BITS > 7) ? CNT_BITS : 7;

   logic             s_valid_ff, s_valid_in;
   mrc_pkg::req_type s_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   mrc_pkg::rsp_type rsp_ff, rsp_in;

   logic [15:0]      timeout_ff;
   logic             waiting_ff, waiting_in;
   logic [7:0]       expected_ff, expected_in;
   logic [15:0]      wait_ff, wait_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       second_ff, second_in;
   logic             overflow_ff, overflow_in;
   logic [15:0]      success_ff, success_in;
   logic [15:0]      failure_ff, failure_in;
   logic [15:0]      exception_ff, exception_in;
   logic [15:0]      retry_ff, retry_in;

   logic req_accept;
   logic stall;
   logic advance;
   logic emit;

   assign stall      = rsp_valid_ff && !rsp_ready;
   assign advance    = s_valid_ff && !stall;
   assign req_ready  = !s_valid_ff || !stall;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      logic [CNT_W-1:0]     cnt_inc;
      mrc_pkg::status_type  st;
      logic [7:0]           b;
      b            = s_item_ff.data_byte;
      cnt_inc      = count_ff + 1'b1;
      st           = mrc_pkg::ST_OK;
      emit         = 1'b0;
      waiting_in   = waiting_ff;
      expected_in  = expected_ff;
      wait_in      = wait_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      overflow_in  = overflow_ff;
      success_in   = success_ff;
      failure_in   = failure_ff;
      exception_in = exception_ff;
      retry_in     = retry_ff;
      rsp_in       = rsp_ff;

      if (advance) begin
         unique case (s_item_ff.operation)
            mrc_pkg::OP_START: begin
               expected_in = b;
               waiting_in  = 1'b1;
               wait_in     = '0;
               count_in    = '0;
               crc_in      = mrc_pkg::CRC_SEED;
               first_in    = '0;
               second_in   = '0;
               overflow_in = 1'b0;
            end
            mrc_pkg::OP_BYTE: begin
               if (waiting_ff) begin
                  if (count_ff < CNT_W'(REPLY_BUFFER_BYTES + 1)) begin
                     if (count_ff == '0) begin
                        first_in = b;
                     end else if (count_ff == CNT_W'(1)) begin
                        second_in = b;
                     end
                     crc_in   = mrc_pkg::crc_feed(crc_ff, b);
                     count_in = cnt_inc;
                     if (cnt_inc > CNT_W'(REPLY_BUFFER_BYTES)) begin
                        overflow_in = 1'b1;
                     end
                  end
                  if (s_item_ff.end_of_frame) begin
                     priority if (count_in < CNT_W'(mrc_pkg::MIN_REPLY_BYTES) || overflow_in) begin
                        st = mrc_pkg::ST_SHORT;
                     end else if (first_in != expected_ff) begin
                        st = mrc_pkg::ST_WRONG_ID;
                     end else if (crc_in != '0) begin
                        st = mrc_pkg::ST_CRC_FAIL;
                     end else if (second_in[mrc_pkg::EXCEPTION_BIT]) begin
                        st           = mrc_pkg::ST_EXCEPTION;
                        exception_in = exception_ff + 16'd1;
                     end else if (!mrc_pkg::known_function(second_in)) begin
                        st = mrc_pkg::ST_ILLEGAL;
                     end else begin
                        st = mrc_pkg::ST_OK;
                     end
                     if (st == mrc_pkg::ST_OK) begin
                        success_in = success_ff + 16'd1;
                        retry_in   = '0;
                     end else begin
                        failure_in = failure_ff + 16'd1;
                        retry_in   = retry_ff + 16'd1;
                     end
                     emit                 = 1'b1;
                     waiting_in           = 1'b0;
                     rsp_in.status        = st;
                     rsp_in.function_code = second_in;
                     rsp_in.reply_length  = count_in[6:0];
                  end
               end
            end
            mrc_pkg::OP_TICK: begin
               if (waiting_ff && count_ff == '0) begin
                  if (wait_ff >= timeout_ff) begin
                     failure_in           = failure_ff + 16'd1;
                     retry_in             = retry_ff + 16'd1;
                     emit                 = 1'b1;
                     waiting_in           = 1'b0;
                     rsp_in.status        = mrc_pkg::ST_TIMEOUT;
                     rsp_in.function_code = '0;
                     rsp_in.reply_length  = '0;
                  end else begin
                     wait_in = wait_ff + 16'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp_in.success_count   = success_in;
      rsp_in.failed_count    = failure_in;
      rsp_in.exception_count = exception_in;
      rsp_in.retry_count     = retry_in;

      if (req_accept) begin
         s_valid_in = 1'b1;
      end else if (advance) begin
         s_valid_in = 1'b0;
      end else begin
         s_valid_in = s_valid_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= mrc_pkg::TIMEOUT_RESET;
         waiting_ff   <= 1'b0;
         expected_ff  <= '0;
         wait_ff      <= '0;
         count_ff     <= '0;
         crc_ff       <= mrc_pkg::CRC_SEED;
         first_ff     <= '0;
         second_ff    <= '0;
         overflow_ff  <= 1'b0;
         success_ff   <= '0;
         failure_ff   <= '0;
         exception_ff <= '0;
         retry_ff     <= '0;
      end else begin
         s_valid_ff   <= s_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
         waiting_ff   <= waiting_in;
         expected_ff  <= expected_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         overflow_ff  <= overflow_in;
         success_ff   <= success_in;
         failure_ff   <= failure_in;
         exception_ff <= exception_in;
         retry_ff     <= retry_in;
      end
   end

   // hold payload registers; only load on transfer or emit
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s_item_ff <= req_data;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

@@ src/mrc_checker.sv @@
// Port-level assertions for the reply checker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_rtu_reply_checker_assert.svh"

module mrc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire mrc_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire mrc_pkg::rsp_type rsp_data
);

   logic req_transfer;
   logic rsp_stalled;
   logic rsp_rise;
   logic status_ok;
   logic status_timeout;
   logic status_legal;
   logic retry_clear;
   logic fields_clear;
   logic xfer_d1_ff;
   logic xfer_d2_ff;
   logic rsp_prev_ff;

   assign req_transfer   = req_valid && req_ready && (req_data.operation != mrc_pkg::OP_START);
   assign rsp_stalled    = rsp_valid && !rsp_ready;
   assign rsp_rise       = rsp_valid && !rsp_prev_ff;
   assign status_ok      = rsp_valid && (rsp_data.status == mrc_pkg::ST_OK);
   assign status_timeout = rsp_valid && (rsp_data.status == mrc_pkg::ST_TIMEOUT);
   assign status_legal   = rsp_data.status <= mrc_pkg::ST_TIMEOUT;
   assign retry_clear    = rsp_data.retry_count == 16'd0;
   assign fields_clear   = (rsp_data.function_code == 8'd0) && (rsp_data.reply_length == 7'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         xfer_d1_ff  <= 1'b0;
         xfer_d2_ff  <= 1'b0;
         rsp_prev_ff <= 1'b0;
      end else begin
         xfer_d1_ff  <= req_transfer;
         xfer_d2_ff  <= xfer_d1_ff;
         rsp_prev_ff <= rsp_valid;
      end
   end

   `MRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_data), "rsp moved")
   `MRC_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, status_legal, "status out of range")
   `MRC_ASSERT_NOW(a_ok_clears_retry, clock, reset, status_ok, retry_clear, "retry count kept")
   `MRC_ASSERT_NOW(a_timeout_fields, clock, reset, status_timeout, fields_clear, "timeout fields")
   `MRC_ASSERT_NOW(a_no_early_rsp, clock, reset, rsp_rise, xfer_d2_ff, "rsp without item")

endmodule

bind modbus_rtu_reply_checker mrc_checker u_mrc_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the Modbus RTU reply checker: directed and random exchanges against a predictor.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   localparam int         BUF_BYTES     = mrc_pkg::REPLY_BUFFER_BYTES_DEFAULT;
   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES = 6;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_ready;
   mrc_pkg::req_type req_data         = '0;
   logic             rsp_valid;
   logic             rsp_ready        = 1'b0;
   mrc_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [15:0]      csr_write_data   = '0;

   logic        armed;
   logic [7:0]  armed_id;
   logic [15:0] idle_ticks;
   logic [6:0]  rx_len;
   logic [15:0] rx_crc;
   logic [7:0]  rx_addr;
   logic [7:0]  rx_func;
   logic        rx_overflow;
   logic [15:0] ok_total;
   logic [15:0] fail_total;
   logic [15:0] exc_total;
   logic [15:0] retry_total;
   logic [15:0] timeout_limit;

   mrc_pkg::rsp_type awaited_statuses[$];
   mrc_pkg::rsp_type oldest_status;
   int               mismatches   = 0;
   int               items_sent   = 0;
   int               quiet_cycles = 0;
   bit               send_gaps    = 1'b1;
   bit               recv_stalls  = 1'b1;

   modbus_rtu_reply_checker u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] x;
      x = acc;
      for (int i = 0; i < 8; i++) begin
         x = (x[0] ^ d[i]) ? ((x >> 1) ^ mrc_pkg::CRC_POLY) : (x >> 1);
      end
      return x;
   endfunction

   function automatic bit is_known_code(input logic [7:0] f);
      case (f)
         mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_INPUTS, mrc_pkg::FC_READ_HOLDING,
         mrc_pkg::FC_READ_INPUT_REGS, mrc_pkg::FC_WRITE_COIL, mrc_pkg::FC_WRITE_REG,
         mrc_pkg::FC_WRITE_COILS, mrc_pkg::FC_WRITE_REGS: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] known_code_at(input int k);
      case (k)
         0: return mrc_pkg::FC_READ_COILS;
         1: return mrc_pkg::FC_READ_INPUTS;
         2: return mrc_pkg::FC_READ_HOLDING;
         3: return mrc_pkg::FC_READ_INPUT_REGS;
         4: return mrc_pkg::FC_WRITE_COIL;
         5: return mrc_pkg::FC_WRITE_REG;
         6: return mrc_pkg::FC_WRITE_COILS;
         default: return mrc_pkg::FC_WRITE_REGS;
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic restart_frame();
      idle_ticks  = '0;
      rx_len      = '0;
      rx_crc      = mrc_pkg::CRC_SEED;
      rx_addr     = '0;
      rx_func     = '0;
      rx_overflow = 1'b0;
   endtask

   task automatic reset_model();
      timeout_limit = mrc_pkg::TIMEOUT_RESET;
      armed         = 1'b0;
      armed_id      = '0;
      restart_frame();
      ok_total      = '0;
      fail_total    = '0;
      exc_total     = '0;
      retry_total   = '0;
   endtask

   task automatic predict_reply_status(input mrc_pkg::req_type it);
      mrc_pkg::rsp_type    r;
      mrc_pkg::status_type st;
      bit                  emitted;
      r       = '0;
      emitted = 1'b0;
      if (it.operation == mrc_pkg::OP_START) begin
         armed_id = it.data_byte;
         restart_frame();
         armed = 1'b1;
      end else if (armed && it.operation == mrc_pkg::OP_BYTE) begin
         if (rx_len < BUF_BYTES + 1) begin
            if (rx_len == 0) begin
               rx_addr = it.data_byte;
            end else if (rx_len == 1) begin
               rx_func = it.data_byte;
            end
            rx_crc = crc16_byte(rx_crc, it.data_byte);
            rx_len = rx_len + 7'd1;
            if (rx_len > BUF_BYTES) begin
               rx_overflow = 1'b1;
            end
         end
         if (it.end_of_frame) begin
            if (rx_len < mrc_pkg::MIN_REPLY_BYTES || rx_overflow) begin
               st = mrc_pkg::ST_SHORT;
            end else if (rx_addr != armed_id) begin
               st = mrc_pkg::ST_WRONG_ID;
            end else if (rx_crc != 16'h0000) begin
               st = mrc_pkg::ST_CRC_FAIL;
            end else if (rx_func[mrc_pkg::EXCEPTION_BIT]) begin
               st = mrc_pkg::ST_EXCEPTION;
            end else if (!is_known_code(rx_func)) begin
               st = mrc_pkg::ST_ILLEGAL;
            end else begin
               st = mrc_pkg::ST_OK;
            end
            if (st == mrc_pkg::ST_EXCEPTION) begin
               exc_total++;
            end
            if (st == mrc_pkg::ST_OK) begin
               ok_total++;
               retry_total = '0;
            end else begin
               fail_total++;
               retry_total++;
            end
            r.status        = st;
            r.function_code = rx_func;
            r.reply_length  = rx_len;
            emitted         = 1'b1;
         end
      end else if (armed && it.operation == mrc_pkg::OP_TICK && rx_len == 0) begin
         if (idle_ticks >= timeout_limit) begin
            fail_total++;
            retry_total++;
            r.status = mrc_pkg::ST_TIMEOUT;
            emitted  = 1'b1;
         end else begin
            idle_ticks++;
         end
      end
      if (emitted) begin
         r.success_count   = ok_total;
         r.failed_count    = fail_total;
         r.exception_count = exc_total;
         r.retry_count     = retry_total;
         awaited_statuses.push_back(r);
         armed = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_statuses.size() == 0) begin
            report_mismatch("unexpected result status", 16'(rsp_data.status), 16'd0);
         end else begin
            oldest_status = awaited_statuses.pop_front();
            if (rsp_data.status !== oldest_status.status)
               report_mismatch("status", 16'(rsp_data.status), 16'(oldest_status.status));
            if (rsp_data.function_code !== oldest_status.function_code)
               report_mismatch("function_code", 16'(rsp_data.function_code),
                               16'(oldest_status.function_code));
            if (rsp_data.reply_length !== oldest_status.reply_length)
               report_mismatch("reply_length", 16'(rsp_data.reply_length),
                               16'(oldest_status.reply_length));
            if (rsp_data.success_count !== oldest_status.success_count)
               report_mismatch("success_count", rsp_data.success_count,
                               oldest_status.success_count);
            if (rsp_data.failed_count !== oldest_status.failed_count)
               report_mismatch("failed_count", rsp_data.failed_count,
                               oldest_status.failed_count);
            if (rsp_data.exception_count !== oldest_status.exception_count)
               report_mismatch("exception_count", rsp_data.exception_count,
                               oldest_status.exception_count);
            if (rsp_data.retry_count !== oldest_status.retry_count)
               report_mismatch("retry_count", rsp_data.retry_count,
                               oldest_status.retry_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (recv_stalls && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] value, input logic last);
      mrc_pkg::req_type it;
      it.operation    = op;
      it.data_byte    = value;
      it.end_of_frame = last;
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_reply_status(it);
      items_sent++;
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (awaited_statuses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] ticks);
      drain_replies();
      csr_write_enable <= 1'b1;
      csr_write_data   <= ticks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timeout_limit = ticks;
   endtask

   task automatic start_exchange(input logic [7:0] addr, input int n_ticks);
      send_item(mrc_pkg::OP_START, addr, 1'($urandom_range(0, 1)));
      repeat (n_ticks) send_item(mrc_pkg::OP_TICK, rand_byte(), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_frame(input logic [7:0] addr, input logic [7:0] func, input int n_data,
                             input bit spoil_crc, input bit mid_tick);
      logic [7:0]  frame[$];
      logic [15:0] acc;
      int          hit;
      frame.push_back(addr);
      frame.push_back(func);
      repeat (n_data) frame.push_back(rand_byte());
      acc = mrc_pkg::CRC_SEED;
      foreach (frame[i]) acc = crc16_byte(acc, frame[i]);
      frame.push_back(acc[7:0]);
      frame.push_back(acc[15:8]);
      if (spoil_crc) begin
         hit = $urandom_range(2, frame.size() - 1);
         frame[hit] = frame[hit] ^ (8'h01 << $urandom_range(0, 7));
      end
      foreach (frame[i]) begin
         if (mid_tick && i == 1) begin
            send_item(mrc_pkg::OP_TICK, rand_byte(), 1'($urandom_range(0, 1)));
         end
         send_item(mrc_pkg::OP_BYTE, frame[i], i == frame.size() - 1);
      end
   endtask

   task automatic send_short(input logic [7:0] addr, input int n_bytes);
      for (int i = 0; i < n_bytes; i++) begin
         send_item(mrc_pkg::OP_BYTE, (i == 0) ? addr : rand_byte(), i == n_bytes - 1);
      end
   endtask

   task automatic test_idle_inputs();
      send_item(mrc_pkg::OP_BYTE, 8'hFF, 1'b1);
      send_item(mrc_pkg::OP_TICK, 8'h00, 1'b0);
      send_item(OP_UNUSED, 8'hFF, 1'b1);
      send_item(OP_UNUSED, 8'h00, 1'b0);
   endtask

   task automatic test_reply_status();
      start_exchange(8'hFF, 0);
      send_frame(8'hFF, mrc_pkg::FC_READ_HOLDING, 1, 1'b0, 1'b0);
      start_exchange(8'h00, 1);
      send_frame(8'h00, 8'h83, 1, 1'b0, 1'b1);
      start_exchange(8'h11, 0);
      send_frame(8'h12, mrc_pkg::FC_READ_COILS, 1, 1'b0, 1'b0);
      start_exchange(8'h11, 0);
      send_frame(8'h11, mrc_pkg::FC_WRITE_REG, 1, 1'b1, 1'b0);
      start_exchange(8'h11, 0);
      send_frame(8'h11, 8'h00, 1, 1'b0, 1'b0);
   endtask

   task automatic test_rearm();
      start_exchange(8'h44, 0);
      send_short(8'h44, 1);
      start_exchange(8'h22, 0);
      send_item(mrc_pkg::OP_BYTE, 8'h22, 1'b0);
      send_item(mrc_pkg::OP_TICK, 8'hFF, 1'b1);
      send_item(OP_UNUSED, 8'hFF, 1'b0);
      start_exchange(8'h33, 0);
      send_frame(8'h33, mrc_pkg::FC_WRITE_REGS, 2, 1'b0, 1'b0);
   endtask

   task automatic test_timeout();
      set_timeout(16'h0000);
      start_exchange(8'h05, 1);
      send_item(mrc_pkg::OP_BYTE, 8'h05, 1'b1);
      set_timeout(16'd2);
      start_exchange(8'h06, 3);
      set_timeout(16'hFFFF);
      start_exchange(8'h07, 5);
      send_frame(8'h07, mrc_pkg::FC_READ_INPUTS, 3, 1'b0, 1'b0);
   endtask

   task automatic test_overflow();
      start_exchange(8'h40, 0);
      send_frame(8'h40, mrc_pkg::FC_READ_INPUT_REGS, BUF_BYTES - 4, 1'b0, 1'b0);
      start_exchange(8'h41, 0);
      send_frame(8'h41, mrc_pkg::FC_READ_INPUT_REGS, BUF_BYTES - 3, 1'b0, 1'b0);
      start_exchange(8'h42, 0);
      send_frame(8'h42, mrc_pkg::FC_WRITE_COILS, BUF_BYTES + 6, 1'b0, 1'b0);
   endtask

   task automatic random_exchange();
      logic [7:0] addr;
      logic [7:0] func;
      int         pick;
      int         n_ticks;
      int         n_data;
      addr = rand_byte();
      func = known_code_at($urandom_range(0, 7));
      n_data = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         send_item(2'($urandom_range(0, 3)), rand_byte(), 1'($urandom_range(0, 1)));
      end else begin
         n_ticks = ($urandom_range(0, 3) == 0)
                   ? $urandom_range(0, (timeout_limit > 20) ? 20 : timeout_limit + 2)
                   : $urandom_range(0, 1);
         start_exchange(addr, n_ticks);
         if (pick < 46) begin
            send_frame(addr, func, n_data, 1'b0, $urandom_range(0, 9) == 0);
         end else if (pick < 54) begin
            send_frame(addr ^ 8'($urandom_range(1, 255)), func, n_data, 1'b0, 1'b0);
         end else if (pick < 62) begin
            send_frame(addr, func, n_data, 1'b1, 1'b0);
         end else if (pick < 70) begin
            send_frame(addr, rand_byte() | 8'h80, n_data, 1'b0, 1'b0);
         end else if (pick < 78) begin
            do func = rand_byte() & 8'h7F; while (is_known_code(func));
            send_frame(addr, func, n_data, 1'b0, 1'b0);
         end else if (pick < 88) begin
            send_short(addr, $urandom_range(1, 4));
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 3)) send_item(mrc_pkg::OP_BYTE, rand_byte(), 1'b0);
            start_exchange(addr, 0);
            send_frame(addr, func, n_data, 1'b0, 1'b0);
         end else if (pick < 96) begin
            send_frame(addr, func, $urandom_range(BUF_BYTES - 5, BUF_BYTES + 6), 1'b0, 1'b0);
         end
      end
   endtask

   task automatic run_random(input int n_items);
      int stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) random_exchange();
   endtask

   task automatic test_random_idling();
      set_timeout(16'($urandom_range(0, 6)));
      run_random(600);
      send_gaps = 1'b0;
      set_timeout(16'd3);
      run_random(300);
      send_gaps = 1'b1;
      recv_stalls = 1'b0;
      set_timeout(16'($urandom_range(1, 20)));
      run_random(350);
      recv_stalls = 1'b1;
   endtask

   task automatic test_full_rate();
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      set_timeout(16'($urandom_range(0, 10)));
      run_random(330);
   endtask

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_inputs();
      test_reply_status();
      test_rearm();
      test_timeout();
      test_overflow();
      test_random_idling();
      test_full_rate();
      drain_replies();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/mrc_pkg.sv
src/modbus_rtu_reply_checker.sv
src/mrc_checker.sv
tb/testbench.sv
